FILE: design/indexed_sequence_store_defines.svh
// assertion macros for the indexed sequence store checker
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ISS_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iss check failed");

// next-cycle implication, sampled on clk, off during reset
`define ISS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iss check failed");

`endif

FILE: design/iss_pkg.sv
package iss_pkg;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_INSERT = 3'd2;
	localparam logic [2:0] OP_ERASE  = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;
	localparam logic [2:0] OP_WRITE  = 3'd5;
	localparam logic [2:0] OP_CLEAR  = 3'd6;

	// broadcast command to every cell of the row
	typedef struct packed {
		logic load;    // cell at target takes the new word
		logic insert;  // cells above target take from below, target takes new word
		logic erase;   // cells at and above target take from above
	} cell_cmd_t;

endpackage

FILE: design/iss_cell.sv
module iss_cell
	import iss_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int IDX_W     = 5,
	parameter int INDEX     = 0
) (
	input  logic                 clk,
	input  cell_cmd_t            cmd,
	input  logic [IDX_W-1:0]     target,
	input  logic [WORD_BITS-1:0] data_in,
	input  logic [WORD_BITS-1:0] below,
	input  logic [WORD_BITS-1:0] above,
	output logic [WORD_BITS-1:0] word
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		if (cmd.erase && (MY_IDX >= target)) begin
			word_q <= above;
		end else if (cmd.insert && (MY_IDX > target)) begin
			word_q <= below;
		end else if ((cmd.load || cmd.insert) && (MY_IDX == target)) begin
			word_q <= data_in;
		end
	end

	assign word = word_q;

endmodule

FILE: design/indexed_sequence_store.sv
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// in       | in_valid/in_ready  | opcode, position, run_count, data_word
// out      | out_valid/out_ready| read_word, error_flag, length_now, is_empty,
//          |                    | first_word, last_word
//
// one beat at a time: an accepted beat passes the exec and result states in turn;
// a valid erase stays in exec while the cell row moves its run one place per cycle
// a finished result sits in the output register; the next beat is taken while it waits
// arst_n clears the count, the state and out_valid; entry contents are not reset
// a stalled out_ready holds the next result in its final state until the register frees
module indexed_sequence_store
	import iss_pkg::*;
#(
	parameter int CAPACITY  = 32,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [4:0]         position,
	input  logic [5:0]         run_count,
	input  logic signed [31:0] data_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] read_word,
	output logic               error_flag,
	output logic [5:0]         length_now,
	output logic               is_empty,
	output logic signed [31:0] first_word,
	output logic signed [31:0] last_word
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// one spare bit so position plus run never wraps
	localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [1:0]           state_q;
	logic [2:0]           op_q;
	logic [CMP_W-1:0]     pos_q;
	logic [5:0]           run_q;
	logic [WORD_BITS-1:0] data_q;
	logic                 err_q;
	logic [CNT_W-1:0]     count_q;

	logic                 out_valid_q;
	logic [31:0]          read_word_q;
	logic                 error_flag_q;
	logic [5:0]           length_now_q;
	logic                 is_empty_q;
	logic [31:0]          first_word_q;
	logic [31:0]          last_word_q;

	logic signed [63:0]   din_wide;
	logic [CMP_W-1:0]     pos_in;
	logic [CMP_W-1:0]     run_in;
	logic [CMP_W-1:0]     cnt_cmp;
	logic                 err_in;
	logic                 out_free;

	cell_cmd_t            cmd;
	logic [IDX_W-1:0]     target;
	logic [WORD_BITS-1:0] cell_word [CAPACITY];
	logic [WORD_BITS-1:0] rd_sel;
	logic [WORD_BITS-1:0] last_sel;
	logic [IDX_W-1:0]     last_idx;

	function automatic logic [31:0] report(input logic [WORD_BITS-1:0] w);
		logic signed [63:0] wide;
		wide = 64'(signed'(w));
		return wide[31:0];
	endfunction

	assign din_wide = 64'(data_word);
	assign pos_in   = CMP_W'(position);
	assign run_in   = CMP_W'(run_count);
	assign cnt_cmp  = CMP_W'(count_q);
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		err_in = 1'b0;
		case (opcode)
			OP_APPEND: err_in = (cnt_cmp >= CMP_W'(CAPACITY));
			OP_REMOVE: err_in = (count_q == '0);
			OP_INSERT: err_in = (pos_in >= cnt_cmp) || (cnt_cmp >= CMP_W'(CAPACITY));
			OP_ERASE:  err_in = (pos_in >= cnt_cmp) || ((pos_in + run_in) > cnt_cmp);
			OP_READ:   err_in = (pos_in >= cnt_cmp);
			OP_WRITE:  err_in = (pos_in >= cnt_cmp);
			default:   err_in = 1'b0;
		endcase
	end

	// append lands at the current end, everything else at the position
	assign target = (op_q == OP_APPEND) ? count_q[IDX_W-1:0] : pos_q[IDX_W-1:0];

	always_comb begin
		cmd = '0;
		if ((state_q == ST_EXEC) && !err_q) begin
			case (op_q)
				OP_APPEND: cmd.load   = 1'b1;
				OP_WRITE:  cmd.load   = 1'b1;
				OP_INSERT: cmd.insert = 1'b1;
				OP_ERASE:  cmd.erase  = (run_q != '0);
				default:   cmd = '0;
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] below_w;
		logic [WORD_BITS-1:0] above_w;
		if (i == 0) begin : g_lo
			assign below_w = data_q;
		end else begin : g_lo
			assign below_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi
			assign above_w = cell_word[i];
		end else begin : g_hi
			assign above_w = cell_word[i+1];
		end
		iss_cell #(
			.WORD_BITS(WORD_BITS),
			.IDX_W    (IDX_W),
			.INDEX    (i)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.target (target),
			.data_in(data_q),
			.below  (below_w),
			.above  (above_w),
			.word   (cell_word[i])
		);
	end

	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	// each cell drives the tap when its index matches
	always_comb begin
		rd_sel   = '0;
		last_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (IDX_W'(i) == pos_q[IDX_W-1:0]) rd_sel = rd_sel | cell_word[i];
			if (IDX_W'(i) == last_idx) last_sel = last_sel | cell_word[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (err_q) begin
						state_q <= ST_RESULT;
					end else begin
						case (op_q)
							OP_APPEND: begin
								count_q <= count_q + CNT_W'(1);
								state_q <= ST_RESULT;
							end
							OP_INSERT: begin
								count_q <= count_q + CNT_W'(1);
								state_q <= ST_RESULT;
							end
							OP_REMOVE: begin
								count_q <= count_q - CNT_W'(1);
								state_q <= ST_RESULT;
							end
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= ST_RESULT;
							end
							OP_ERASE: begin
								// one place per cycle until the run is gone
								if (run_q != '0) begin
									count_q <= count_q - CNT_W'(1);
								end else begin
									state_q <= ST_RESULT;
								end
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_RESULT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			op_q   <= opcode;
			pos_q  <= pos_in;
			run_q  <= run_count;
			data_q <= din_wide[WORD_BITS-1:0];
			err_q  <= err_in;
		end else if ((state_q == ST_EXEC) && (op_q == OP_ERASE) && (run_q != '0)) begin
			run_q <= run_q - 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if ((state_q == ST_RESULT) && out_free) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			read_word_q  <= ((op_q == OP_READ) && !err_q) ? report(rd_sel) : 32'd0;
			error_flag_q <= err_q;
			length_now_q <= 6'(count_q);
			is_empty_q   <= (count_q == '0);
			first_word_q <= (count_q == '0) ? 32'd0 : report(cell_word[0]);
			last_word_q  <= (count_q == '0) ? 32'd0 : report(last_sel);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_word  = read_word_q;
	assign error_flag = error_flag_q;
	assign length_now = length_now_q;
	assign is_empty   = is_empty_q;
	assign first_word = first_word_q;
	assign last_word  = last_word_q;

endmodule

FILE: design/iss_checker.sv
`include "indexed_sequence_store_defines.svh"

module iss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] read_word,
	input logic               error_flag,
	input logic [5:0]         length_now,
	input logic               is_empty,
	input logic signed [31:0] first_word,
	input logic signed [31:0] last_word
);

	logic [103:0] out_payload;

	assign out_payload = {read_word, error_flag, length_now, is_empty, first_word, last_word};

	// a stalled result beat holds
	`ISS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

	// one beat in flight: a taken beat closes the input for the next cycle
	`ISS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// empty list reports zero length and zero ends
	`ISS_ASSERT_NOW(a_empty_ends, out_valid && is_empty, {length_now, first_word, last_word} == '0)

	// rejected operations never return a word
	`ISS_ASSERT_NOW(a_err_no_read, out_valid && error_flag, read_word == 32'sd0)

endmodule

bind indexed_sequence_store iss_checker u_iss_checker (.*);
